@@ design/trdd_pkg.sv @@
// Shared constants, types and codes of the tagged ring deque dispatcher.
package trdd_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  localparam int HND_W      = WORD_WIDTH - 1;
  localparam int SLOT_W     = WORD_WIDTH + 1;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int PAYLOAD_W  = 1 + HND_W + WORD_WIDTH;
  localparam int IN_DATA_W  = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int CMD_W      = 2;
  localparam int OUT_USER_W = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCHEDULE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP,
    ST_POP_H,
    ST_POP_A,
    ST_EMIT,
    ST_WR_FN,
    ST_WR_ARG
  } state_t;

endpackage

@@ design/trdd_ptr_alu.sv @@
// Shared ring pointer adder: head plus an offset, wrapped into the ring.
module trdd_ptr_alu (
  input  trdd_pkg::ptr_t base,
  input  trdd_pkg::cnt_t offset,
  output trdd_pkg::ptr_t sum
);
  import trdd_pkg::*;

  logic [CNT_W:0] raw;
  logic [CNT_W:0] wrapped;

  // Both operands stay below the ring size, so one conditional subtract wraps.
  assign raw     = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
  assign wrapped = (raw >= (CNT_W+1)'(DEPTH)) ? raw - (CNT_W+1)'(DEPTH) : raw;
  assign sum     = wrapped[PTR_W-1:0];

endmodule

@@ design/tagged_ring_deque_dispatcher.sv @@
// Top level of the tagged ring deque dispatcher.
//
//  Channel  Dir  Handshake           Payload
//  s_*      in   s_tvalid/s_tready   s_tuser: command; s_tdata: has_arg, handler, arg
//  m_*      out  m_tvalid/m_tready   m_tuser: dispatched, evicted; m_tdata: entry; m_tlast
//
// One request at a time. A push writes the handler slot and, with an argument, the argument
// slot; a schedule pops the head entry with its tagged argument, or reports an empty deque;
// an eviction pops the head entry ahead of a push. Slot reads are registered, and every head
// and tail step goes through the one pointer adder. Reset (rst, synchronous) empties the deque.
// Slot contents survive reset. A stalled result holds in the output register, and
// the sequencer waits only when it has the next result ready.
module tagged_ring_deque_dispatcher (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [0] has_arg, [HND_W:1] handler, [2*WORD_WIDTH-1:HND_W+1] arg, zero pad above
  input  logic [trdd_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] command
  input  logic [trdd_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [HND_W-1:0] out_handler, [HND_W] out_has_arg, [2*WORD_WIDTH-1:WORD_WIDTH] out_arg
  output logic [trdd_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] dispatched, [1] evicted
  output logic [trdd_pkg::OUT_USER_W-1:0]   m_tuser,
  output logic                              m_tlast
);
  import trdd_pkg::*;

  state_t state, state_next;
  ptr_t   head, head_next;
  cnt_t   count, count_next;
  logic [1:0] npop, npop_next;

  logic [CMD_W-1:0]      cmd, cmd_next;
  logic                  has, has_next;
  logic [HND_W-1:0]      hnd, hnd_next;
  logic [WORD_WIDTH-1:0] arg, arg_next;

  logic  res_disp, res_disp_next;
  slot_t res_fn, res_fn_next;
  slot_t res_arg, res_arg_next;

  logic                  m_tvalid_next;
  logic [OUT_DATA_W-1:0] m_tdata_next;
  logic [OUT_USER_W-1:0] m_tuser_next;
  logic                  m_tlast_next;

  slot_t slots [DEPTH];
  slot_t rd_data;
  logic  rd_en;
  logic  wr_en;
  ptr_t  wr_addr;
  slot_t wr_data;

  cnt_t  alu_off;
  ptr_t  alu_sum;

  cnt_t  need;
  cnt_t  free_slots;
  logic  room_short;
  logic  is_back;
  logic  is_sched;
  logic  out_free;

  trdd_ptr_alu u_alu (
    .base   (head),
    .offset (alu_off),
    .sum    (alu_sum)
  );

  assign need       = has ? cnt_t'(2) : cnt_t'(1);
  assign free_slots = cnt_t'(DEPTH) - count;
  assign room_short = (free_slots < need) && (count != '0);
  assign is_back    = (cmd == CMD_PUSH_BACK);
  assign is_sched   = (cmd == CMD_SCHEDULE);
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= slots[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      npop     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      npop     <= npop_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    has      <= has_next;
    hnd      <= hnd_next;
    arg      <= arg_next;
    res_disp <= res_disp_next;
    res_fn   <= res_fn_next;
    res_arg  <= res_arg_next;
    m_tdata  <= m_tdata_next;
    m_tuser  <= m_tuser_next;
    m_tlast  <= m_tlast_next;
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    npop_next     = npop;
    cmd_next      = cmd;
    has_next      = has;
    hnd_next      = hnd;
    arg_next      = arg;
    res_disp_next = res_disp;
    res_fn_next   = res_fn;
    res_arg_next  = res_arg;
    m_tvalid_next = m_tvalid;
    m_tdata_next  = m_tdata;
    m_tuser_next  = m_tuser;
    m_tlast_next  = m_tlast;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = alu_sum;
    wr_data       = '0;
    alu_off       = cnt_t'(1);

    if (m_tvalid && m_tready) begin
      m_tvalid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd_next   = s_tuser;
          has_next   = s_tdata[0];
          hnd_next   = s_tdata[HND_W:1];
          arg_next   = s_tdata[HND_W+WORD_WIDTH:HND_W+1];
          npop_next  = '0;
          state_next = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (is_sched) begin
          if (count != '0) begin
            state_next = ST_POP;
          end else begin
            // Empty deque: report an all-zero result.
            res_disp_next = 1'b0;
            res_fn_next   = '0;
            res_arg_next  = '0;
            state_next    = ST_EMIT;
          end
        end else if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) begin
          if (room_short) begin
            state_next = ST_POP;
          end else if (is_back || !has) begin
            state_next = ST_WR_FN;
          end else begin
            state_next = ST_WR_ARG;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_POP: begin
        rd_en         = 1'b1;
        alu_off       = cnt_t'(1);
        head_next     = alu_sum;
        count_next    = count - cnt_t'(1);
        res_disp_next = 1'b1;
        state_next    = ST_POP_H;
      end

      ST_POP_H: begin
        res_fn_next = rd_data;
        // A tagged handler takes its argument slot along, if there is one.
        if (rd_data[WORD_WIDTH] && count != '0) begin
          rd_en      = 1'b1;
          alu_off    = cnt_t'(1);
          head_next  = alu_sum;
          count_next = count - cnt_t'(1);
          state_next = ST_POP_A;
        end else begin
          res_arg_next = '0;
          state_next   = ST_EMIT;
        end
      end

      ST_POP_A: begin
        res_arg_next = rd_data;
        state_next   = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = '0;
          m_tdata_next[HND_W-1:0]                 = res_fn[HND_W-1:0];
          m_tdata_next[HND_W]                     = res_fn[WORD_WIDTH];
          m_tdata_next[2*WORD_WIDTH-1:WORD_WIDTH] = res_arg[WORD_WIDTH-1:0];
          m_tuser_next  = {res_disp && !is_sched, res_disp};
          npop_next     = npop + 2'd1;
          // Counts already reflect this pop, so the room check is final here.
          if (is_sched) begin
            m_tlast_next = 1'b1;
            state_next   = ST_IDLE;
          end else if (room_short && npop == 2'd0) begin
            m_tlast_next = 1'b0;
            state_next   = ST_POP;
          end else begin
            m_tlast_next = 1'b1;
            state_next   = (is_back || !has) ? ST_WR_FN : ST_WR_ARG;
          end
        end
      end

      ST_WR_FN: begin
        wr_en      = 1'b1;
        wr_data    = {has, 1'b0, hnd};
        count_next = count + cnt_t'(1);
        if (is_back) begin
          alu_off    = count;
          state_next = has ? ST_WR_ARG : ST_IDLE;
        end else begin
          alu_off    = cnt_t'(DEPTH - 1);
          head_next  = alu_sum;
          state_next = ST_IDLE;
        end
      end

      ST_WR_ARG: begin
        wr_en      = 1'b1;
        wr_data    = {1'b0, arg};
        count_next = count + cnt_t'(1);
        if (is_back) begin
          alu_off    = count;
          state_next = ST_IDLE;
        end else begin
          alu_off    = cnt_t'(DEPTH - 1);
          head_next  = alu_sum;
          state_next = ST_WR_FN;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/trdd_checker.sv @@
// Port-level checks of the tagged ring deque dispatcher, bound to the top level.
module trdd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [trdd_pkg::OUT_DATA_W-1:0]   m_tdata,
  input logic [trdd_pkg::OUT_USER_W-1:0]   m_tuser,
  input logic                              m_tlast
);
  import trdd_pkg::*;

  // Reset leaves the block ready and with no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // One request at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one is in work");

  // An empty-deque report is a lone, all-zero final result.
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1] && m_tdata == '0)
    else $error("malformed empty-deque result");

  // An eviction is always a real dispatch.
  a_evict_dispatched: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("evicted result without dispatch");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind tagged_ring_deque_dispatcher trdd_checker u_trdd_checker (.*);
